>>> rtl/cbo_pkg.sv
// Shared types, constants and arithmetic helpers of the cubic Bezier offset sampler.
package cbo_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int T_FRAC_BITS = 16;

    localparam int P_W     = 32;
    localparam int HW_W    = 16;
    localparam int AS_W    = 7;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam int T_W     = T_FRAC_BITS + 1;
    localparam int T_ONE   = 1 << T_FRAC_BITS;
    localparam int T_EPS   = (T_ONE + 50000) / 100000;
    localparam int T_SPAN  = T_ONE - 2 * T_EPS;
    localparam int SPAN2   = 2 * T_SPAN;
    localparam int SPAN2_W = T_FRAC_BITS + 1;
    localparam int DIV_CNT_W = $clog2(SPAN2_W + 1);

    localparam int IDX_W   = $clog2(MAX_SAMPLES);
    localparam int DEN_W   = $clog2(2 * MAX_SAMPLES - 1);

    localparam int C_W     = 38;
    localparam int MAG_W   = C_W - 1;
    localparam int POS_W   = $clog2(MAG_W);
    localparam int NORM_W  = 30;
    localparam int NORM_POS = NORM_W - 1;
    localparam int SQ_W    = 2 * NORM_W + 2;
    localparam int SQ_STEPS = SQ_W / 2;
    localparam int LEN_W   = SQ_STEPS;
    localparam int PROD_W  = NORM_W + HW_W;
    localparam int NUM_W   = PROD_W + 1;
    localparam int Q_W     = HW_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SAMPLES = CFG_IDX_W'(1);
    localparam logic [HW_W-1:0] HALF_WIDTH_RESET     = HW_W'(23040);
    localparam logic [AS_W-1:0] ACTIVE_SAMPLES_RESET = AS_W'(64);

    typedef struct packed {
        logic               ready;
        logic [SPAN2_W-1:0] quo;
        logic [DEN_W-1:0]   rem;
        logic [DEN_W-1:0]   den;
        logic [DEN_W-1:0]   first_r;
        logic [IDX_W-1:0]   n_last;
    } t_step;

    typedef struct packed {
        logic signed [C_W-1:0] xa;
        logic signed [C_W-1:0] xb;
        logic signed [C_W-1:0] xc;
        logic signed [C_W-1:0] xd;
        logic signed [C_W-1:0] ya;
        logic signed [C_W-1:0] yb;
        logic signed [C_W-1:0] yc;
        logic signed [C_W-1:0] yd;
    } t_coef;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_tag;

    typedef struct packed {
        t_coef          coef;
        logic [T_W-1:0] t;
        t_tag           tag;
    } t_s0;

    typedef struct packed {
        logic signed [C_W-1:0] cx;
        logic signed [C_W-1:0] cy;
        logic [NORM_W-1:0]     ax;
        logic [NORM_W-1:0]     ay;
        logic                  sx;
        logic                  sy;
        logic                  zero;
        t_tag                  tag;
    } t_geom;

    typedef struct packed {
        logic signed [C_W-1:0] cx;
        logic signed [C_W-1:0] cy;
        logic                  sx;
        logic                  sy;
        logic                  zero;
        t_tag                  tag;
        logic [PROD_W-1:0]     px;
        logic [PROD_W-1:0]     py;
    } t_oside;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [P_W-1:0]   cx;
        logic [P_W-1:0]   cy;
        logic [P_W-1:0]   lx;
        logic [P_W-1:0]   ly;
        logic [P_W-1:0]   rx;
        logic [P_W-1:0]   ry;
        logic             zero;
        logic             last;
    } t_result;

    // Multiply by t and round back to 8 fraction bits, ties toward +infinity.
    function automatic logic signed [C_W-1:0] mul_t(input logic signed [C_W-1:0] v,
                                                    input logic [T_W-1:0] t);
        logic signed [C_W+T_W:0] p;
        p = v * $signed({1'b0, t});
        p = p + $signed({{(C_W+1){1'b0}}, 1'b1, {(T_FRAC_BITS-1){1'b0}}});
        return C_W'(p >>> T_FRAC_BITS);
    endfunction

    // Saturate to a signed 32-bit word.
    function automatic logic [P_W-1:0] sat32(input logic signed [C_W:0] v);
        logic [P_W-1:0] res;
        if (v[C_W:P_W-1] == {(C_W-P_W+2){1'b0}} || v[C_W:P_W-1] == {(C_W-P_W+2){1'b1}}) begin
            res = v[P_W-1:0];
        end else if (v[C_W]) begin
            res = {1'b1, {(P_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(P_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

>>> rtl/cbo_param_div.sv
// Serial divider that splits the per-sample t step into quotient and remainder.
module cbo_param_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [cbo_pkg::AS_W-1:0]    i_active_samples,
    input  logic                        i_kick,
    output cbo_pkg::t_step              o_step
);

    logic                           r_pend;
    logic                           r_run;
    logic [cbo_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [cbo_pkg::SPAN2_W-1:0]    r_dvd;
    logic [cbo_pkg::SPAN2_W-1:0]    r_quo;
    logic [cbo_pkg::DEN_W-1:0]      r_rem;
    logic [cbo_pkg::DEN_W-1:0]      r_den;
    logic [cbo_pkg::IDX_W-1:0]      r_nl;

    logic [cbo_pkg::AS_W-1:0]       n_eff;
    logic [cbo_pkg::AS_W-1:0]       n_m1;
    logic [cbo_pkg::DEN_W:0]        trial;
    logic                           take;

    always_comb begin
        if (i_active_samples < cbo_pkg::AS_W'(2)) begin
            n_eff = cbo_pkg::AS_W'(2);
        end else if (i_active_samples > cbo_pkg::AS_W'(cbo_pkg::MAX_SAMPLES)) begin
            n_eff = cbo_pkg::AS_W'(cbo_pkg::MAX_SAMPLES);
        end else begin
            n_eff = i_active_samples;
        end
        n_m1  = n_eff - cbo_pkg::AS_W'(1);
        trial = {r_rem, r_dvd[cbo_pkg::SPAN2_W-1]};
        take  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b1;
            r_run  <= 1'b0;
        end else if (i_kick) begin
            r_pend <= 1'b1;
        end else if (r_pend) begin
            r_pend <= 1'b0;
            r_run  <= 1'b1;
            r_cnt  <= '0;
            r_dvd  <= cbo_pkg::SPAN2_W'(cbo_pkg::SPAN2);
            r_quo  <= '0;
            r_rem  <= '0;
            r_den  <= cbo_pkg::DEN_W'({n_m1, 1'b0});
            r_nl   <= cbo_pkg::IDX_W'(n_m1);
        end else if (r_run) begin
            // shift in one dividend bit, restore when the trial goes negative
            r_dvd <= {r_dvd[cbo_pkg::SPAN2_W-2:0], 1'b0};
            r_quo <= {r_quo[cbo_pkg::SPAN2_W-2:0], take};
            r_rem <= take ? cbo_pkg::DEN_W'(trial - {1'b0, r_den})
                          : cbo_pkg::DEN_W'(trial);
            r_cnt <= r_cnt + cbo_pkg::DIV_CNT_W'(1);
            if (r_cnt == cbo_pkg::DIV_CNT_W'(cbo_pkg::SPAN2_W - 1)) begin
                r_run <= 1'b0;
            end
        end
    end

    assign o_step.ready   = !r_pend && !r_run;
    assign o_step.quo     = r_quo;
    assign o_step.rem     = r_rem;
    assign o_step.den     = r_den;
    assign o_step.first_r = cbo_pkg::DEN_W'(r_nl);
    assign o_step.n_last  = r_nl;

endmodule

>>> rtl/cbo_sample_gen.sv
// Coefficient register and sample sequencer that issues one t per cycle.
module cbo_sample_gen (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic signed [cbo_pkg::P_W-1:0] i_p0_x,
    input  logic signed [cbo_pkg::P_W-1:0] i_p0_y,
    input  logic signed [cbo_pkg::P_W-1:0] i_p1_x,
    input  logic signed [cbo_pkg::P_W-1:0] i_p1_y,
    input  logic signed [cbo_pkg::P_W-1:0] i_p2_x,
    input  logic signed [cbo_pkg::P_W-1:0] i_p2_y,
    input  logic signed [cbo_pkg::P_W-1:0] i_p3_x,
    input  logic signed [cbo_pkg::P_W-1:0] i_p3_y,
    input  cbo_pkg::t_step                i_step,
    output logic                          o_valid,
    output cbo_pkg::t_s0                  o_s0
);

    cbo_pkg::t_coef                 r_coef;
    logic                           r_act;
    logic [cbo_pkg::IDX_W-1:0]      r_idx;
    logic [cbo_pkg::T_W-1:0]        r_q;
    logic [cbo_pkg::DEN_W-1:0]      r_r;
    logic                           r_vld;
    cbo_pkg::t_s0                   r_s0;

    cbo_pkg::t_coef                 n_coef;
    logic signed [cbo_pkg::C_W-1:0] x0, x1, x2, x3, y0, y1, y2, y3;
    logic                           last_now;
    logic                           accept;
    logic [cbo_pkg::DEN_W:0]        rsum;

    always_comb begin
        x0 = cbo_pkg::C_W'(i_p0_x);
        x1 = cbo_pkg::C_W'(i_p1_x);
        x2 = cbo_pkg::C_W'(i_p2_x);
        x3 = cbo_pkg::C_W'(i_p3_x);
        y0 = cbo_pkg::C_W'(i_p0_y);
        y1 = cbo_pkg::C_W'(i_p1_y);
        y2 = cbo_pkg::C_W'(i_p2_y);
        y3 = cbo_pkg::C_W'(i_p3_y);
        n_coef.xa = x3 - x0 + (x1 <<< 1) + x1 - (x2 <<< 1) - x2;
        n_coef.xb = (x0 <<< 1) + x0 - (x1 <<< 2) - (x1 <<< 1) + (x2 <<< 1) + x2;
        n_coef.xc = (x1 <<< 1) + x1 - (x0 <<< 1) - x0;
        n_coef.xd = x0;
        n_coef.ya = y3 - y0 + (y1 <<< 1) + y1 - (y2 <<< 1) - y2;
        n_coef.yb = (y0 <<< 1) + y0 - (y1 <<< 2) - (y1 <<< 1) + (y2 <<< 1) + y2;
        n_coef.yc = (y1 <<< 1) + y1 - (y0 <<< 1) - y0;
        n_coef.yd = y0;
    end

    assign last_now = r_act && (r_idx == i_step.n_last);
    assign o_busy   = !i_step.ready || (r_act && !last_now);
    assign accept   = i_start && !o_busy;
    assign rsum     = {1'b0, r_r} + {1'b0, i_step.rem};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_vld <= 1'b0;
        end else begin
            r_vld <= r_act;
            if (accept) begin
                r_act <= 1'b1;
            end else if (last_now) begin
                r_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_coef <= n_coef;
            r_idx  <= '0;
            r_q    <= '0;
            r_r    <= i_step.first_r;
        end else if (r_act) begin
            // advance t by the step; carry the remainder over the denominator
            r_idx <= r_idx + cbo_pkg::IDX_W'(1);
            if (rsum >= {1'b0, i_step.den}) begin
                r_r <= cbo_pkg::DEN_W'(rsum - {1'b0, i_step.den});
                r_q <= r_q + i_step.quo + cbo_pkg::T_W'(1);
            end else begin
                r_r <= cbo_pkg::DEN_W'(rsum);
                r_q <= r_q + i_step.quo;
            end
        end
        r_s0.coef     <= r_coef;
        r_s0.t        <= cbo_pkg::T_W'(cbo_pkg::T_EPS) + r_q;
        r_s0.tag.idx  <= r_idx;
        r_s0.tag.last <= last_now;
    end

    assign o_valid = r_vld;
    assign o_s0    = r_s0;

endmodule

>>> rtl/cbo_curve_eval.sv
// Horner evaluation of point and derivative, then tangent magnitude normalization.
module cbo_curve_eval (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cbo_pkg::t_s0    i_s0,
    output logic            o_valid,
    output cbo_pkg::t_geom  o_geom
);

    // stage 1
    logic                           r1_vld;
    logic signed [cbo_pkg::C_W-1:0] r1_hx, r1_hy, r1_dx, r1_dy;
    logic signed [cbo_pkg::C_W-1:0] r1_xc, r1_yc, r1_xd, r1_yd;
    logic [cbo_pkg::T_W-1:0]        r1_t;
    cbo_pkg::t_tag                  r1_tag;
    // stage 2
    logic                           r2_vld;
    logic signed [cbo_pkg::C_W-1:0] r2_hx, r2_hy, r2_dx, r2_dy, r2_xd, r2_yd;
    logic [cbo_pkg::T_W-1:0]        r2_t;
    cbo_pkg::t_tag                  r2_tag;
    // stage 3
    logic                           r3_vld;
    logic signed [cbo_pkg::C_W-1:0] r3_cx, r3_cy;
    logic [cbo_pkg::MAG_W-1:0]      r3_ax, r3_ay;
    logic                           r3_sx, r3_sy, r3_zero;
    cbo_pkg::t_tag                  r3_tag;
    // stage 4
    logic                           r4_vld;
    logic signed [cbo_pkg::C_W-1:0] r4_cx, r4_cy;
    logic [cbo_pkg::MAG_W-1:0]      r4_ax, r4_ay;
    logic                           r4_sx, r4_sy, r4_zero, r4_right;
    logic [cbo_pkg::POS_W-1:0]      r4_sh;
    cbo_pkg::t_tag                  r4_tag;
    // stage 5
    logic                           r5_vld;
    cbo_pkg::t_geom                 r5_geom;

    logic signed [cbo_pkg::C_W-1:0] xa3, ya3, xb2, yb2;
    logic [cbo_pkg::MAG_W-1:0]      mag_or;
    logic [cbo_pkg::POS_W-1:0]      pos;

    assign xa3 = i_s0.coef.xa + (i_s0.coef.xa <<< 1);
    assign ya3 = i_s0.coef.ya + (i_s0.coef.ya <<< 1);
    assign xb2 = i_s0.coef.xb <<< 1;
    assign yb2 = i_s0.coef.yb <<< 1;

    always_comb begin
        mag_or = r3_ax | r3_ay;
        pos    = '0;
        for (int b = 0; b < cbo_pkg::MAG_W; b++) begin
            if (mag_or[b]) begin
                pos = cbo_pkg::POS_W'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_hx  <= cbo_pkg::mul_t(i_s0.coef.xa, i_s0.t) + i_s0.coef.xb;
        r1_hy  <= cbo_pkg::mul_t(i_s0.coef.ya, i_s0.t) + i_s0.coef.yb;
        r1_dx  <= cbo_pkg::mul_t(xa3, i_s0.t) + xb2;
        r1_dy  <= cbo_pkg::mul_t(ya3, i_s0.t) + yb2;
        r1_xc  <= i_s0.coef.xc;
        r1_yc  <= i_s0.coef.yc;
        r1_xd  <= i_s0.coef.xd;
        r1_yd  <= i_s0.coef.yd;
        r1_t   <= i_s0.t;
        r1_tag <= i_s0.tag;

        r2_hx  <= cbo_pkg::mul_t(r1_hx, r1_t) + r1_xc;
        r2_hy  <= cbo_pkg::mul_t(r1_hy, r1_t) + r1_yc;
        r2_dx  <= cbo_pkg::mul_t(r1_dx, r1_t) + r1_xc;
        r2_dy  <= cbo_pkg::mul_t(r1_dy, r1_t) + r1_yc;
        r2_xd  <= r1_xd;
        r2_yd  <= r1_yd;
        r2_t   <= r1_t;
        r2_tag <= r1_tag;

        r3_cx   <= cbo_pkg::mul_t(r2_hx, r2_t) + r2_xd;
        r3_cy   <= cbo_pkg::mul_t(r2_hy, r2_t) + r2_yd;
        r3_ax   <= cbo_pkg::MAG_W'(r2_dx[cbo_pkg::C_W-1] ? -r2_dx : r2_dx);
        r3_ay   <= cbo_pkg::MAG_W'(r2_dy[cbo_pkg::C_W-1] ? -r2_dy : r2_dy);
        r3_sx   <= r2_dx[cbo_pkg::C_W-1];
        r3_sy   <= r2_dy[cbo_pkg::C_W-1];
        r3_zero <= (r2_dx == '0) && (r2_dy == '0);
        r3_tag  <= r2_tag;

        // place the larger magnitude's top bit at NORM_POS
        r4_cx    <= r3_cx;
        r4_cy    <= r3_cy;
        r4_ax    <= r3_ax;
        r4_ay    <= r3_ay;
        r4_sx    <= r3_sx;
        r4_sy    <= r3_sy;
        r4_zero  <= r3_zero;
        r4_tag   <= r3_tag;
        r4_right <= (pos >= cbo_pkg::POS_W'(cbo_pkg::NORM_POS));
        r4_sh    <= (pos >= cbo_pkg::POS_W'(cbo_pkg::NORM_POS))
                    ? pos - cbo_pkg::POS_W'(cbo_pkg::NORM_POS)
                    : cbo_pkg::POS_W'(cbo_pkg::NORM_POS) - pos;

        r5_geom.cx   <= r4_cx;
        r5_geom.cy   <= r4_cy;
        r5_geom.ax   <= r4_right ? cbo_pkg::NORM_W'(r4_ax >> r4_sh)
                                 : cbo_pkg::NORM_W'(r4_ax << r4_sh);
        r5_geom.ay   <= r4_right ? cbo_pkg::NORM_W'(r4_ay >> r4_sh)
                                 : cbo_pkg::NORM_W'(r4_ay << r4_sh);
        r5_geom.sx   <= r4_sx;
        r5_geom.sy   <= r4_sy;
        r5_geom.zero <= r4_zero;
        r5_geom.tag  <= r4_tag;
    end

    assign o_valid = r5_vld;
    assign o_geom  = r5_geom;

endmodule

>>> rtl/cbo_offset_unit.sv
// Tangent length by pipelined square root, offset by pipelined division, final sums.
module cbo_offset_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  cbo_pkg::t_geom              i_geom,
    input  logic [cbo_pkg::HW_W-1:0]    i_half_width,
    output logic                        o_valid,
    output cbo_pkg::t_result            o_res
);

    localparam int SQN = cbo_pkg::SQ_STEPS;
    localparam int DVN = cbo_pkg::Q_W;

    // products stage
    logic                              ra_vld;
    logic [2*cbo_pkg::NORM_W-1:0]      ra_sqx, ra_sqy;
    cbo_pkg::t_oside                   ra_side;

    // square root pipeline
    logic                              r_sq_vld  [0:SQN];
    logic [cbo_pkg::SQ_W-1:0]          r_sq_v    [0:SQN];
    logic [cbo_pkg::SQ_W-1:0]          r_sq_r    [0:SQN];
    cbo_pkg::t_oside                   r_sq_side [0:SQN];

    // division pipeline, both offsets side by side
    logic                              r_dv_vld  [0:DVN];
    logic [cbo_pkg::LEN_W-1:0]         r_dv_len  [0:DVN];
    logic [cbo_pkg::NUM_W-1:0]         r_dv_rx   [0:DVN];
    logic [cbo_pkg::NUM_W-1:0]         r_dv_ry   [0:DVN];
    logic [cbo_pkg::Q_W-1:0]           r_dv_qx   [0:DVN];
    logic [cbo_pkg::Q_W-1:0]           r_dv_qy   [0:DVN];
    cbo_pkg::t_oside                   r_dv_side [0:DVN];

    logic                              r_o_vld;
    cbo_pkg::t_result                  r_o_res;

    logic [cbo_pkg::LEN_W-1:0]         len_fin;
    logic signed [cbo_pkg::C_W:0]      fx, fy, ox, oy;
    cbo_pkg::t_oside                   fs;

    always_ff @(posedge i_clk) begin
        ra_sqx          <= i_geom.ax * i_geom.ax;
        ra_sqy          <= i_geom.ay * i_geom.ay;
        ra_side.cx      <= i_geom.cx;
        ra_side.cy      <= i_geom.cy;
        ra_side.sx      <= i_geom.sx;
        ra_side.sy      <= i_geom.sy;
        ra_side.zero    <= i_geom.zero;
        ra_side.tag     <= i_geom.tag;
        ra_side.px      <= i_geom.ax * i_half_width;
        ra_side.py      <= i_geom.ay * i_half_width;

        r_sq_v[0]    <= cbo_pkg::SQ_W'(ra_sqx) + cbo_pkg::SQ_W'(ra_sqy);
        r_sq_r[0]    <= '0;
        r_sq_side[0] <= ra_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_vld      <= 1'b0;
            r_sq_vld[0] <= 1'b0;
        end else begin
            ra_vld      <= i_valid;
            r_sq_vld[0] <= ra_vld;
        end
    end

    // one result bit of the integer square root per stage
    for (genvar k = 0; k < SQN; k++) begin : g_sq
        logic [cbo_pkg::SQ_W-1:0] s_bit, s_trial, n_v, n_r;
        always_comb begin
            s_bit   = cbo_pkg::SQ_W'(1) << (cbo_pkg::SQ_W - 2 - 2 * k);
            s_trial = r_sq_r[k] + s_bit;
            if (r_sq_v[k] >= s_trial) begin
                n_v = r_sq_v[k] - s_trial;
                n_r = (r_sq_r[k] >> 1) + s_bit;
            end else begin
                n_v = r_sq_v[k];
                n_r = r_sq_r[k] >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
            r_sq_v[k+1]    <= n_v;
            r_sq_r[k+1]    <= n_r;
            r_sq_side[k+1] <= r_sq_side[k];
        end
    end

    assign len_fin = cbo_pkg::LEN_W'(r_sq_r[SQN]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else begin
            r_dv_vld[0] <= r_sq_vld[SQN];
        end
        // round to nearest: add half the divisor up front
        r_dv_len[0]  <= len_fin;
        r_dv_rx[0]   <= cbo_pkg::NUM_W'(r_sq_side[SQN].px)
                        + cbo_pkg::NUM_W'(len_fin >> 1);
        r_dv_ry[0]   <= cbo_pkg::NUM_W'(r_sq_side[SQN].py)
                        + cbo_pkg::NUM_W'(len_fin >> 1);
        r_dv_qx[0]   <= '0;
        r_dv_qy[0]   <= '0;
        r_dv_side[0] <= r_sq_side[SQN];
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 0; j < DVN; j++) begin : g_dv
        logic [cbo_pkg::NUM_W:0]   s_dvs;
        logic                      s_tx, s_ty;
        logic [cbo_pkg::Q_W-1:0]   s_qb;
        always_comb begin
            s_dvs = (cbo_pkg::NUM_W+1)'(r_dv_len[j]) << (DVN - 1 - j);
            s_tx  = ({1'b0, r_dv_rx[j]} >= s_dvs);
            s_ty  = ({1'b0, r_dv_ry[j]} >= s_dvs);
            s_qb  = cbo_pkg::Q_W'(1) << (DVN - 1 - j);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
            r_dv_len[j+1]  <= r_dv_len[j];
            r_dv_rx[j+1]   <= s_tx ? cbo_pkg::NUM_W'({1'b0, r_dv_rx[j]} - s_dvs) : r_dv_rx[j];
            r_dv_ry[j+1]   <= s_ty ? cbo_pkg::NUM_W'({1'b0, r_dv_ry[j]} - s_dvs) : r_dv_ry[j];
            r_dv_qx[j+1]   <= s_tx ? (r_dv_qx[j] | s_qb) : r_dv_qx[j];
            r_dv_qy[j+1]   <= s_ty ? (r_dv_qy[j] | s_qb) : r_dv_qy[j];
            r_dv_side[j+1] <= r_dv_side[j];
        end
    end

    always_comb begin
        fs = r_dv_side[DVN];
        fx = (cbo_pkg::C_W+1)'(fs.cx);
        fy = (cbo_pkg::C_W+1)'(fs.cy);
        // normal is (-dy, dx): x offset opposes the sign of dy
        if (fs.zero) begin
            ox = '0;
            oy = '0;
        end else begin
            ox = fs.sy ? $signed((cbo_pkg::C_W+1)'(r_dv_qy[DVN]))
                       : -$signed((cbo_pkg::C_W+1)'(r_dv_qy[DVN]));
            oy = fs.sx ? -$signed((cbo_pkg::C_W+1)'(r_dv_qx[DVN]))
                       : $signed((cbo_pkg::C_W+1)'(r_dv_qx[DVN]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_dv_vld[DVN];
        end
        r_o_res.idx  <= fs.tag.idx;
        r_o_res.last <= fs.tag.last;
        r_o_res.zero <= fs.zero;
        r_o_res.cx   <= cbo_pkg::sat32(fx);
        r_o_res.cy   <= cbo_pkg::sat32(fy);
        r_o_res.lx   <= cbo_pkg::sat32(fx + ox);
        r_o_res.ly   <= cbo_pkg::sat32(fy + oy);
        r_o_res.rx   <= cbo_pkg::sat32(fx - ox);
        r_o_res.ry   <= cbo_pkg::sat32(fy - oy);
    end

    assign o_valid = r_o_vld;
    assign o_res   = r_o_res;

endmodule

>>> rtl/cubic_bezier_offset_sampler.sv
// Top level of the cubic Bezier offset sampler: config registers and pipeline.
//
// A curve beat (four control points, Q24.8) is taken when i_start is high and
// o_busy is low. The block then issues active_samples samples (clamped to 2..64)
// into a fully pipelined datapath, one per cycle, so a curve occupies the entry
// while its samples issue and the next curve may be started on the cycle its
// last sample issues. Each sample leaves on the result ports for one cycle,
// marked by o_valid; the receiver cannot stall, so results must be captured
// when o_valid is high. Per sample the block gives the curve point and the two
// points offset by +/- half_width along the unit normal; where the tangent is
// exactly zero the offsets are zero and o_zero_tangent is set. The latency is
// set by the 31-stage square root and 17-stage divider that form the unit
// normal. After reset, and after each write of active_samples, o_busy stays
// high while a serial divider works out the t step. Configuration is always
// ready and must be written only while the block is idle.
module cubic_bezier_offset_sampler (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic signed [cbo_pkg::P_W-1:0]       i_p0_x,
    input  logic signed [cbo_pkg::P_W-1:0]       i_p0_y,
    input  logic signed [cbo_pkg::P_W-1:0]       i_p1_x,
    input  logic signed [cbo_pkg::P_W-1:0]       i_p1_y,
    input  logic signed [cbo_pkg::P_W-1:0]       i_p2_x,
    input  logic signed [cbo_pkg::P_W-1:0]       i_p2_y,
    input  logic signed [cbo_pkg::P_W-1:0]       i_p3_x,
    input  logic signed [cbo_pkg::P_W-1:0]       i_p3_y,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [cbo_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [cbo_pkg::CFG_DAT_W-1:0]        i_cfg_data,
    output logic                                 o_valid,
    output logic [cbo_pkg::IDX_W-1:0]            o_sample_index,
    output logic signed [cbo_pkg::P_W-1:0]       o_center_x,
    output logic signed [cbo_pkg::P_W-1:0]       o_center_y,
    output logic signed [cbo_pkg::P_W-1:0]       o_left_x,
    output logic signed [cbo_pkg::P_W-1:0]       o_left_y,
    output logic signed [cbo_pkg::P_W-1:0]       o_right_x,
    output logic signed [cbo_pkg::P_W-1:0]       o_right_y,
    output logic                                 o_zero_tangent,
    output logic                                 o_last_sample
);

    logic [cbo_pkg::HW_W-1:0]   r_half_width;
    logic [cbo_pkg::AS_W-1:0]   r_active_samples;

    logic                       cfg_wr;
    logic                       kick;
    cbo_pkg::t_step             step;
    logic                       s0_vld;
    cbo_pkg::t_s0               s0;
    logic                       geom_vld;
    cbo_pkg::t_geom             geom;
    logic                       res_vld;
    cbo_pkg::t_result           res;

    // config writes are always accepted and registered directly
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign kick        = cfg_wr && (i_cfg_index == cbo_pkg::REG_ACTIVE_SAMPLES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width     <= cbo_pkg::HALF_WIDTH_RESET;
            r_active_samples <= cbo_pkg::ACTIVE_SAMPLES_RESET;
        end else if (cfg_wr) begin
            // unknown indexes drop silently
            if (i_cfg_index == cbo_pkg::REG_HALF_WIDTH) begin
                r_half_width <= i_cfg_data[cbo_pkg::HW_W-1:0];
            end else if (i_cfg_index == cbo_pkg::REG_ACTIVE_SAMPLES) begin
                r_active_samples <= i_cfg_data[cbo_pkg::AS_W-1:0];
            end
        end
    end

    // t step = 2*SPAN / 2*(n-1), recomputed whenever the sample count changes
    cbo_param_div u_div (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_active_samples (r_active_samples),
        .i_kick           (kick),
        .o_step           (step)
    );

    // hold the coefficients of the current curve and issue one t per cycle
    cbo_sample_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_p0_x  (i_p0_x),
        .i_p0_y  (i_p0_y),
        .i_p1_x  (i_p1_x),
        .i_p1_y  (i_p1_y),
        .i_p2_x  (i_p2_x),
        .i_p2_y  (i_p2_y),
        .i_p3_x  (i_p3_x),
        .i_p3_y  (i_p3_y),
        .i_step  (step),
        .o_valid (s0_vld),
        .o_s0    (s0)
    );

    // point and derivative by Horner, then normalize the tangent magnitude
    cbo_curve_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s0_vld),
        .i_s0    (s0),
        .o_valid (geom_vld),
        .o_geom  (geom)
    );

    // unit normal scaled by half_width, added to and subtracted from the point
    cbo_offset_unit u_ofs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (geom_vld),
        .i_geom       (geom),
        .i_half_width (r_half_width),
        .o_valid      (res_vld),
        .o_res        (res)
    );

    assign o_valid        = res_vld;
    assign o_sample_index = res.idx;
    assign o_center_x     = res.cx;
    assign o_center_y     = res.cy;
    assign o_left_x       = res.lx;
    assign o_left_y       = res.ly;
    assign o_right_x      = res.rx;
    assign o_right_y      = res.ry;
    assign o_zero_tangent = res.zero;
    assign o_last_sample  = res.last;

endmodule

>>> rtl/cbo_checker.sv
// Port-level checker for the sample stream of the cubic Bezier offset sampler.
module cbo_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_valid,
    input  logic [cbo_pkg::IDX_W-1:0]     o_sample_index,
    input  logic [cbo_pkg::P_W-1:0]       o_center_x,
    input  logic [cbo_pkg::P_W-1:0]       o_center_y,
    input  logic [cbo_pkg::P_W-1:0]       o_left_x,
    input  logic [cbo_pkg::P_W-1:0]       o_left_y,
    input  logic [cbo_pkg::P_W-1:0]       o_right_x,
    input  logic [cbo_pkg::P_W-1:0]       o_right_y,
    input  logic                          o_zero_tangent,
    input  logic                          o_last_sample
);

    // samples of one curve come without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_sample |=> o_valid)
        else $error("gap inside a curve's sample run");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_sample |=>
        o_sample_index == $past(o_sample_index) + cbo_pkg::IDX_W'(1))
        else $error("sample index does not advance by one");

    // a run starts only after idle or after a last sample
    a_first_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_sample_index == '0) |-> !$past(o_valid) || $past(o_last_sample))
        else $error("sample zero inside a running curve");

    a_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_tangent |->
        o_left_x == o_center_x && o_left_y == o_center_y &&
        o_right_x == o_center_x && o_right_y == o_center_y)
        else $error("nonzero offset on a zero tangent");

endmodule

bind cubic_bezier_offset_sampler cbo_checker u_cbo_checker (.*);
